### rtl/pff_pkg.sv
// Shared types, constants and character helpers for the printf field formatter.
`timescale 1ns / 1ps
`default_nettype none

package pff_pkg;

    localparam int MAX_WIDTH_DEF = 64;
    localparam int CNT_W         = 8;
    localparam int DBUF_DEPTH    = 16;
    localparam int DBUF_AW       = $clog2(DBUF_DEPTH);
    localparam int DLEN_W        = DBUF_AW + 1;

    // ceil(2^35 / 10): x / 10 == (x * RECIP10) >> 35 for any 32-bit x
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    typedef enum logic [2:0] {
        KIND_LIT  = 3'd0,
        KIND_CHAR = 3'd1,
        KIND_DEC  = 3'd2,
        KIND_UDEC = 3'd3,
        KIND_HEXL = 3'd4,
        KIND_HEXU = 3'd5,
        KIND_PTR  = 3'd6,
        KIND_PCT  = 3'd7
    } kind_t;

    // Command into the digit unit
    typedef struct packed {
        logic        start;
        logic        hex;
        logic [63:0] value;
    } pff_dcmd_t;

    // One digit out of the digit unit, least significant first
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [3:0] digit;
    } pff_dig_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? CH_A_UP : CH_A_LO;
            if (d < 4'd10) begin
                digit_char = CH_ZERO + {4'b0000, d};
            end else begin
                digit_char = base + {4'b0000, d} - 8'd10;
            end
        end
    endfunction

endpackage

`default_nettype wire

### rtl/pff_digit_unit.sv
// Shared digit extractor: nibble shift for hex, reciprocal divide by ten for decimal.
`timescale 1ns / 1ps
`default_nettype none

module pff_digit_unit
    import pff_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  pff_dcmd_t cmd,
    output pff_dig_t  dig
);

    logic        busy_reg, busy_next;
    logic        phase_reg, phase_next;
    logic        hex_reg;
    logic [63:0] val_reg, val_next;
    logic [63:0] prod_reg, prod_next;
    logic [28:0] quo;
    logic [3:0]  q10_lo;
    logic [3:0]  rem;

    assign prod_next = val_reg[31:0] * RECIP10;
    assign quo       = prod_reg[63:35];
    // remainder is below ten, so the low four bits of x - 10q are enough
    assign q10_lo    = {quo[0], 3'b000} + {quo[2:0], 1'b0};
    assign rem       = val_reg[3:0] - q10_lo;

    always_comb begin
        dig        = '0;
        busy_next  = busy_reg;
        phase_next = phase_reg;
        val_next   = val_reg;
        if (cmd.start) begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            val_next   = cmd.value;
        end else if (busy_reg) begin
            if (hex_reg) begin
                dig.valid = 1'b1;
                dig.digit = val_reg[3:0];
                dig.last  = (val_reg[63:4] == 60'd0);
                val_next  = {4'b0000, val_reg[63:4]};
                if (dig.last) begin
                    busy_next = 1'b0;
                end
            end else if (!phase_reg) begin
                // wait for the product register to load
                phase_next = 1'b1;
            end else begin
                dig.valid  = 1'b1;
                dig.digit  = rem;
                dig.last   = (quo == 29'd0);
                val_next   = {35'd0, quo};
                phase_next = 1'b0;
                if (dig.last) begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
        val_reg  <= val_next;
        prod_reg <= prod_next;
        if (cmd.start) begin
            hex_reg <= cmd.hex;
        end
    end

endmodule

`default_nettype wire

### rtl/printf_field_formatter.sv
// Decimal conversions extract up to 10 digits, hex up to 8 and pointer up to 16; the ST_CALC and
// ST_SIZE sizing states then run before the first character reaches the output register.
// Throughput: one character per cycle while m_tready is high; the next conversion is accepted
// once the last character of the current one is loaded into the output register.
// Literal and illegal conversions go from acceptance straight to the emit state for their single character.
// Reset (aresetn low, synchronous) returns the sequencer to idle and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module printf_field_formatter
    import pff_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [63:0] value, [64] left_align, [65] zero_pad, [72:66] width, [73] has_precision,
    // [79:74] precision
    input  logic [79:0] s_tdata,
    // [2:0] kind
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_char
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // [0] error
    output logic [0:0]  m_tuser
);

    localparam logic [CNT_W-1:0] MAXW  = CNT_W'(MAX_WIDTH);
    localparam logic [CNT_W-1:0] MAXPR = CNT_W'(MAX_WIDTH - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIGITS = 5'b00010,
        ST_CALC   = 5'b00100,
        ST_SIZE   = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [7:0]         lit_reg, lit_next;
    logic               use_lit_reg, use_lit_next;
    logic               err_reg, err_next;
    logic               upper_reg, upper_next;
    logic               la_reg, la_next;
    logic               zok_reg, zok_next;
    logic               hp_reg, hp_next;
    logic [CNT_W-1:0]   w_reg, w_next;
    logic [5:0]         pr_reg, pr_next;
    logic [7:0]         pre0_reg, pre0_next;
    logic [7:0]         pre1_reg, pre1_next;
    logic [1:0]         plen_reg, plen_next;
    logic [DLEN_W-1:0]  dlen_reg, dlen_next;
    logic [CNT_W-1:0]   z_reg, z_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   padl_reg, padl_next;
    logic [CNT_W-1:0]   padr_reg, padr_next;
    logic [1:0]         pcnt_reg, pcnt_next;
    logic [DLEN_W-1:0]  dcnt_reg, dcnt_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [7:0]         m_char_reg, m_char_next;
    logic               m_last_reg, m_last_next;
    logic               m_err_reg, m_err_next;
    logic [3:0]         dbuf [DBUF_DEPTH];

    pff_dcmd_t          dcmd;
    pff_dig_t           dig;

    kind_t              in_kind;
    logic [63:0]        in_value;
    logic               in_la, in_zp, in_hp;
    logic [CNT_W-1:0]   in_w, in_pr;
    logic [31:0]        x32, xabs;
    logic               neg, illegal, zero_skip, can_load, accept;
    logic [DLEN_W-1:0]  dcnt_m1;
    logic [DBUF_AW-1:0] rd_idx;
    logic [CNT_W-1:0]   z0, gap;
    logic               wider;

    assign in_kind  = kind_t'(s_tuser);
    assign in_value = s_tdata[63:0];
    assign in_la    = s_tdata[64];
    assign in_zp    = s_tdata[65];
    assign in_hp    = s_tdata[73];
    assign in_w     = ({1'b0, s_tdata[72:66]} > MAXW) ? MAXW : {1'b0, s_tdata[72:66]};
    assign in_pr    = ({2'b00, s_tdata[79:74]} > MAXPR) ? MAXPR : {2'b00, s_tdata[79:74]};

    assign x32  = in_value[31:0];
    assign neg  = (in_kind == KIND_DEC) && x32[31];
    assign xabs = neg ? (32'd0 - x32) : x32;
    assign zero_skip = in_hp && (in_pr == '0) && (xabs == 32'd0);
    assign illegal = (((in_kind == KIND_CHAR) || (in_kind == KIND_PTR)) && (in_zp || in_hp)) ||
                     (((in_kind == KIND_DEC) || (in_kind == KIND_UDEC) ||
                       (in_kind == KIND_HEXL) || (in_kind == KIND_HEXU)) && in_la && in_zp);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign can_load = !m_tvalid_reg || m_tready;
    assign dcnt_m1  = dcnt_reg - DLEN_W'(1);
    assign rd_idx   = dcnt_m1[DBUF_AW-1:0];

    assign z0    = (hp_reg && ({2'b00, pr_reg} > CNT_W'(dlen_reg)))
                   ? ({2'b00, pr_reg} - CNT_W'(dlen_reg)) : '0;
    assign wider = (w_reg > len_reg);
    assign gap   = w_reg - len_reg;

    pff_digit_unit u_digits (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (dcmd),
        .dig     (dig)
    );

    always_comb begin
        state_next    = state_reg;
        lit_next      = lit_reg;
        use_lit_next  = use_lit_reg;
        err_next      = err_reg;
        upper_next    = upper_reg;
        la_next       = la_reg;
        zok_next      = zok_reg;
        hp_next       = hp_reg;
        w_next        = w_reg;
        pr_next       = pr_reg;
        pre0_next     = pre0_reg;
        pre1_next     = pre1_reg;
        plen_next     = plen_reg;
        dlen_next     = dlen_reg;
        z_next        = z_reg;
        len_next      = len_reg;
        padl_next     = padl_reg;
        padr_next     = padr_reg;
        pcnt_next     = pcnt_reg;
        dcnt_next     = dcnt_reg;
        total_next    = total_reg;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;
        m_err_next    = m_err_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        dcmd          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    err_next     = 1'b0;
                    use_lit_next = 1'b0;
                    plen_next    = 2'd0;
                    dlen_next    = '0;
                    upper_next   = (in_kind == KIND_HEXU);
                    la_next      = in_la;
                    w_next       = in_w;
                    pr_next      = in_pr[5:0];
                    hp_next      = 1'b0;
                    zok_next     = 1'b0;
                    priority if (in_kind == KIND_LIT || illegal) begin
                        // single character, no padding
                        lit_next     = (in_kind == KIND_LIT) ? in_value[7:0] : 8'h00;
                        err_next     = (in_kind != KIND_LIT);
                        use_lit_next = 1'b1;
                        padl_next    = '0;
                        padr_next    = '0;
                        pcnt_next    = 2'd0;
                        z_next       = '0;
                        dcnt_next    = DLEN_W'(1);
                        total_next   = CNT_W'(1);
                        state_next   = ST_EMIT;
                    end else begin
                        unique case (in_kind)
                            KIND_CHAR: begin
                                lit_next     = in_value[7:0];
                                use_lit_next = 1'b1;
                                dlen_next    = DLEN_W'(1);
                                state_next   = ST_CALC;
                            end
                            KIND_PCT: begin
                                lit_next     = CH_PCT;
                                use_lit_next = 1'b1;
                                dlen_next    = DLEN_W'(1);
                                zok_next     = in_zp && !in_la;
                                state_next   = ST_CALC;
                            end
                            KIND_PTR: begin
                                pre0_next  = CH_ZERO;
                                pre1_next  = CH_X;
                                plen_next  = 2'd2;
                                dcmd.start = 1'b1;
                                dcmd.hex   = 1'b1;
                                dcmd.value = in_value;
                                state_next = ST_DIGITS;
                            end
                            default: begin
                                pre0_next = CH_MINUS;
                                plen_next = neg ? 2'd1 : 2'd0;
                                hp_next   = in_hp;
                                zok_next  = !in_hp && in_zp && !in_la;
                                if (zero_skip) begin
                                    state_next = ST_CALC;
                                end else begin
                                    dcmd.start = 1'b1;
                                    dcmd.hex   = (in_kind == KIND_HEXL) ||
                                                 (in_kind == KIND_HEXU);
                                    dcmd.value = {32'd0, xabs};
                                    state_next = ST_DIGITS;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_DIGITS: begin
                if (dig.valid) begin
                    dlen_next = dlen_reg + DLEN_W'(1);
                    if (dig.last) begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                z_next     = z0;
                len_next   = CNT_W'(plen_reg) + z0 + CNT_W'(dlen_reg);
                state_next = ST_SIZE;
            end
            ST_SIZE: begin
                total_next = wider ? w_reg : len_reg;
                if (zok_reg) begin
                    z_next    = z_reg + (wider ? gap : '0);
                    padl_next = '0;
                    padr_next = '0;
                end else begin
                    padl_next = (wider && !la_reg) ? gap : '0;
                    padr_next = (wider && la_reg) ? gap : '0;
                end
                pcnt_next  = plen_reg;
                dcnt_next  = dlen_reg;
                // a zero value with zero precision and no width prints nothing
                state_next = (wider || len_reg != '0) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (can_load) begin
                    m_tvalid_next = 1'b1;
                    m_last_next   = (total_reg == CNT_W'(1));
                    m_err_next    = err_reg;
                    total_next    = total_reg - CNT_W'(1);
                    priority if (padl_reg != '0) begin
                        m_char_next = CH_SPACE;
                        padl_next   = padl_reg - CNT_W'(1);
                    end else if (pcnt_reg != 2'd0) begin
                        m_char_next = pre0_reg;
                        pre0_next   = pre1_reg;
                        pcnt_next   = pcnt_reg - 2'd1;
                    end else if (z_reg != '0) begin
                        m_char_next = CH_ZERO;
                        z_next      = z_reg - CNT_W'(1);
                    end else if (dcnt_reg != '0) begin
                        m_char_next = use_lit_reg ? lit_reg : digit_char(dbuf[rd_idx], upper_reg);
                        dcnt_next   = dcnt_m1;
                    end else begin
                        m_char_next = CH_SPACE;
                        padr_next   = padr_reg - CNT_W'(1);
                    end
                    if (total_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        lit_reg     <= lit_next;
        use_lit_reg <= use_lit_next;
        err_reg     <= err_next;
        upper_reg   <= upper_next;
        la_reg      <= la_next;
        zok_reg     <= zok_next;
        hp_reg      <= hp_next;
        w_reg       <= w_next;
        pr_reg      <= pr_next;
        pre0_reg    <= pre0_next;
        pre1_reg    <= pre1_next;
        plen_reg    <= plen_next;
        dlen_reg    <= dlen_next;
        z_reg       <= z_next;
        len_reg     <= len_next;
        padl_reg    <= padl_next;
        padr_reg    <= padr_next;
        pcnt_reg    <= pcnt_next;
        dcnt_reg    <= dcnt_next;
        total_reg   <= total_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
        m_err_reg   <= m_err_next;
    end

    // digits land least significant first
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIGITS && dig.valid) begin
            dbuf[dlen_reg[DBUF_AW-1:0]] <= dig.digit;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_char_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_err_reg;

    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("error transaction without last");

    a_digits_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        dig.valid |-> (state_reg == ST_DIGITS))
        else $error("digit produced outside digit phase");

    a_literal_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_kind == KIND_LIT) |=> (state_reg == ST_EMIT && total_reg == CNT_W'(1)))
        else $error("literal did not go straight to emit");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && can_load && total_reg == CNT_W'(1)) |=>
        (state_reg == ST_IDLE && m_tvalid && m_tlast))
        else $error("final character did not return sequencer to idle");

endmodule

`default_nettype wire
